[rtl/core/pts_pkg.sv]
// Shared types and constants of the periodic task scheduler.
package pts_pkg;

  // Fixed field widths.
  localparam int unsigned TASK_IDX_W = 2;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MAX_TASKS  = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD1    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD2    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD3    = 3'd4;

  // Register reset values.
  localparam logic [COUNT_W-1:0]  TASK_COUNT_RST = 3'd4;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd100;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // take the timer value of an input beat
    logic advance;  // advance the last chosen task's wake time
    logic scan;     // examine one task
    logic commit;   // load the result register and the chosen task
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic due;      // task under examination is already due
    logic last;     // task under examination is the last active one
    logic none;     // no active tasks
  } stat_t;

endpackage

[rtl/core/pts_datapath.sv]
// Datapath of the periodic task scheduler: registers, wake times and the scan.
module pts_datapath #(
  parameter int unsigned TASK_SLOTS = 4,
  parameter int unsigned TIME_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [TIME_BITS-1:0]            now_i,
  input  pts_pkg::cmd_t                   cmd_i,
  output pts_pkg::stat_t                  stat_o,
  output logic [pts_pkg::TASK_IDX_W-1:0]  task_index_o,
  output logic                            run_now_o,
  output logic [TIME_BITS-1:0]            wake_time_o
);

  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [TIME_BITS-1:0] OverrunMax = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam logic [pts_pkg::COUNT_W-1:0] SlotCnt = pts_pkg::COUNT_W'(TASK_SLOTS);

  // Configuration registers.
  logic [pts_pkg::COUNT_W-1:0]  task_count_q;
  logic [pts_pkg::PERIOD_W-1:0] period_q [pts_pkg::MAX_TASKS];

  // Scheduler state.
  logic [TIME_BITS-1:0]            wake_q [TASK_SLOTS];
  logic [pts_pkg::TASK_IDX_W-1:0]  chosen_q;

  // Working registers of one decision.
  logic [TIME_BITS-1:0]            now_q;
  logic [IW-1:0]                   scan_i_q;
  logic [TIME_BITS-1:0]            best_sleep_q;
  logic [pts_pkg::TASK_IDX_W-1:0]  best_idx_q;
  logic [TIME_BITS-1:0]            best_wake_q;
  logic                            due_q;

  // Result register.
  logic [pts_pkg::TASK_IDX_W-1:0]  out_idx_q;
  logic                            out_run_q;
  logic [TIME_BITS-1:0]            out_wake_q;

  logic [pts_pkg::COUNT_W-1:0]     count_eff;
  logic [IW-1:0]                   rd_idx;
  logic [TIME_BITS-1:0]            wake_rd;
  logic [TIME_BITS-1:0]            wake_sum;
  logic [TIME_BITS-1:0]            overrun;
  logic [TIME_BITS-1:0]            sleep;
  logic                            is_due;
  logic [pts_pkg::COUNT_W-1:0]     scan_pos;

  // Active task count saturates at the number of task slots.
  assign count_eff = (task_count_q > SlotCnt) ? SlotCnt : task_count_q;

  // One wake time is read per cycle: the advanced task, or the one being scanned.
  assign rd_idx   = cmd_i.advance ? chosen_q[IW-1:0] : scan_i_q;
  assign wake_rd  = wake_q[rd_idx];
  assign wake_sum = wake_rd + TIME_BITS'(period_q[chosen_q]);

  // Wrapped overrun and wait of the scanned task.
  assign overrun  = now_q - wake_rd;
  assign sleep    = wake_rd - now_q;
  assign is_due   = overrun < OverrunMax;
  assign scan_pos = pts_pkg::COUNT_W'(scan_i_q) + pts_pkg::COUNT_W'(1);

  assign stat_o.due  = is_due;
  assign stat_o.last = (scan_pos == count_eff);
  assign stat_o.none = (count_eff == '0);

  assign task_index_o = out_idx_q;
  assign run_now_o    = out_run_q;
  assign wake_time_o  = out_wake_q;

  // Configuration writes; indexes beyond the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= pts_pkg::TASK_COUNT_RST;
      for (int k = 0; k < pts_pkg::MAX_TASKS; k++) begin
        period_q[k] <= pts_pkg::PERIOD_RST;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pts_pkg::CFG_TASK_COUNT: task_count_q <= cfg_data_i[pts_pkg::COUNT_W-1:0];
        pts_pkg::CFG_PERIOD0:    period_q[0]  <= cfg_data_i;
        pts_pkg::CFG_PERIOD1:    period_q[1]  <= cfg_data_i;
        pts_pkg::CFG_PERIOD2:    period_q[2]  <= cfg_data_i;
        pts_pkg::CFG_PERIOD3:    period_q[3]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Wake times and the chosen task.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TASK_SLOTS; k++) begin
        wake_q[k] <= '0;
      end
      chosen_q <= '0;
    end else begin
      if (cmd_i.advance) begin
        wake_q[rd_idx] <= wake_sum;
      end
      if (cmd_i.commit) begin
        chosen_q <= best_idx_q;
      end
    end
  end

  // Scan of the active tasks, one per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= now_i;
    end
    if (cmd_i.advance) begin
      // The advanced task stands as the choice until a scan finds a better one.
      scan_i_q     <= '0;
      best_sleep_q <= '1;
      best_idx_q   <= chosen_q;
      best_wake_q  <= wake_sum;
      due_q        <= 1'b0;
    end else if (cmd_i.scan) begin
      scan_i_q <= scan_i_q + IW'(1);
      if (is_due) begin
        best_idx_q  <= pts_pkg::TASK_IDX_W'(scan_i_q);
        best_wake_q <= wake_rd;
        due_q       <= 1'b1;
      end else if (sleep < best_sleep_q) begin
        best_sleep_q <= sleep;
        best_idx_q   <= pts_pkg::TASK_IDX_W'(scan_i_q);
        best_wake_q  <= wake_rd;
      end
    end
    if (cmd_i.commit) begin
      out_idx_q  <= best_idx_q;
      out_run_q  <= due_q;
      out_wake_q <= best_wake_q;
    end
  end

endmodule

[rtl/core/pts_controller.sv]
// Controller state machine of the periodic task scheduler.
module pts_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  pts_pkg::stat_t  stat_i,
  output pts_pkg::cmd_t   cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register is free when empty or when its beat leaves now.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ADVANCE;
        end
      end
      ST_ADVANCE: begin
        cmd_o.advance = 1'b1;
        state_d       = stat_i.none ? ST_FINISH : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.due || stat_i.last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/periodic_task_scheduler.sv]
// Periodic task scheduler: picks the next task from up to four periodic tasks.
// For each accepted input beat: advance the last chosen task's wake time, scan
// the active tasks (0 to 4) one at a time through the single wake-time read port,
// then commit the result. The scan may stop early at a due task. A new beat is
// taken only in the idle state, so one decision ends before the next begins. A
// result not taken holds the next decision.
// Reset clears all wake times and the chosen task, task count to 4, periods to 100.
module periodic_task_scheduler #(
  parameter int unsigned TASK_SLOTS = 4,
  parameter int unsigned TIME_BITS  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pts_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0]  s_axis_tdata,  // current_time
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [((TIME_BITS+10)/8)*8-1:0] m_axis_tdata   // task_index, run_now, wake_time
);

  localparam int unsigned OutW = ((TIME_BITS + 10) / 8) * 8;

  pts_pkg::cmd_t                   cmd;
  pts_pkg::stat_t                  stat;
  logic [pts_pkg::TASK_IDX_W-1:0]  task_index;
  logic                            run_now;
  logic [TIME_BITS-1:0]            wake_time;

  // Sequencing of one decision.
  pts_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Registers, wake times and the scan.
  pts_datapath #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .now_i        (s_axis_tdata[TIME_BITS-1:0]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .task_index_o (task_index),
    .run_now_o    (run_now),
    .wake_time_o  (wake_time)
  );

  // Result beat packed from the lowest bit up, zero filled.
  assign m_axis_tdata = OutW'({wake_time, run_now, task_index});

endmodule
